FILE: rtl/mexp_pkg.sv
package mexp_pkg;

  // operand width of base, exponent, modulus and result
  localparam int unsigned OPERAND_BITS = 30;
  localparam int unsigned CNT_BITS     = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0] operand_t;

  localparam operand_t MODULUS_RESET = OPERAND_BITS'(23);

  // operand selection for the shared modular multiplier
  typedef enum logic {
    MUL_ACC_BASE,
    MUL_BASE_SQR
  } mul_sel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     wr_base;
    logic     wr_acc;
    logic     exp_shift;
    logic     out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mul_done;
    logic exp_zero;
    logic exp_lsb;
    logic mod_small;
  } dp_stat_t;

endpackage

FILE: rtl/modular_exponentiation.sv
// Modular exponentiation, base ** exponent mod modulus, square-and-multiply.
// Input channel: in_valid_i / in_stall_o with base_value_i and exponent_i.
// Output channel: out_valid_o / out_stall_i with power_result_o.
// The modulus is written with modulus_we_i / modulus_i; the user must write it
// only while the block is idle, since the block itself does not enforce this.
// One item is worked on at a time; in_stall_o is high from acceptance until
// the result has moved into the output register. All work goes through one
// shift-and-add modular multiplier. From acceptance, the block first reduces
// the base, then for each exponent bit up to the highest set one it runs a
// test, a multiply into the accumulator when the bit is set, and a squaring
// of the base; a final test and a done state finish the item. The next item
// can be accepted in the cycle after the output load.
// A modulus below 2 skips the loop and gives 0.
// The output register holds a result while out_stall_i is high; the next item
// is accepted and computed meanwhile, but waits before its output load.
// Reset empties the output register and sets the modulus to 23.
module modular_exponentiation import mexp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     modulus_we_i,
  input  operand_t modulus_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  operand_t base_value_i,
  input  operand_t exponent_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output operand_t power_result_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mexp_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .modulus_we_i   (modulus_we_i),
    .modulus_i      (modulus_i),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .power_result_o (power_result_o)
  );

endmodule

FILE: rtl/mexp_dpath.sv
module mexp_dpath import mexp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     modulus_we_i,
  input  operand_t modulus_i,
  input  operand_t base_value_i,
  input  operand_t exponent_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output operand_t power_result_o
);

  operand_t mod_q;
  operand_t base_q;
  operand_t exp_q;
  operand_t acc_q;
  operand_t x_q;
  operand_t y_q;
  operand_t r_q;
  operand_t result_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic busy_q;

  logic [OPERAND_BITS:0] dbl;
  logic [OPERAND_BITS:0] dbl_red_w;
  logic [OPERAND_BITS:0] sum;
  logic [OPERAND_BITS:0] sum_red_w;
  operand_t dbl_red;
  operand_t step_r;
  logic last;

  // one step of the shift-and-add modular multiply, multiplier msb first
  always_comb begin
    dbl       = {r_q, 1'b0};
    dbl_red_w = (dbl >= {1'b0, mod_q}) ? dbl - {1'b0, mod_q} : dbl;
    dbl_red   = dbl_red_w[OPERAND_BITS-1:0];
    sum       = {1'b0, dbl_red} + (x_q[OPERAND_BITS-1] ? {1'b0, y_q} : '0);
    sum_red_w = (sum >= {1'b0, mod_q}) ? sum - {1'b0, mod_q} : sum;
    step_r    = sum_red_w[OPERAND_BITS-1:0];
  end

  assign last = (cnt_q == CNT_BITS'(OPERAND_BITS - 1));

  assign stat_o.mul_done  = busy_q && last;
  assign stat_o.exp_zero  = (exp_q == '0);
  assign stat_o.exp_lsb   = exp_q[0];
  assign stat_o.mod_small = (mod_q[OPERAND_BITS-1:1] == '0);

  assign power_result_o = result_q;

  // modulus register and multiplier activity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= MODULUS_RESET;
      busy_q <= 1'b0;
    end else begin
      if (modulus_we_i) begin
        mod_q <= modulus_i;
      end
      if (cmd_i.load || cmd_i.mul_start) begin
        busy_q <= 1'b1;
      end else if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // multiplier operands; loading an item starts the base reduction as base * 1
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= base_value_i;
      y_q   <= OPERAND_BITS'(1);
      r_q   <= '0;
      cnt_q <= '0;
    end else if (cmd_i.mul_start) begin
      unique case (cmd_i.mul_sel)
        MUL_ACC_BASE: x_q <= acc_q;
        MUL_BASE_SQR: x_q <= base_q;
        default:      x_q <= base_q;
      endcase
      y_q   <= base_q;
      r_q   <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      r_q   <= step_r;
      x_q   <= {x_q[OPERAND_BITS-2:0], 1'b0};
      cnt_q <= cnt_q + CNT_BITS'(1);
    end
  end

  // working registers of the exponentiation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      exp_q <= exponent_i;
      acc_q <= OPERAND_BITS'(1);
    end else begin
      if (cmd_i.exp_shift) begin
        exp_q <= {1'b0, exp_q[OPERAND_BITS-1:1]};
      end
      if (cmd_i.wr_acc) begin
        acc_q <= step_r;
      end
    end
    if (cmd_i.wr_base) begin
      base_q <= step_r;
    end
    if (cmd_i.out_load) begin
      result_q <= stat_o.mod_small ? '0 : acc_q;
    end
  end

endmodule

FILE: rtl/mexp_ctrl.sv
module mexp_ctrl import mexp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_TEST = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // sequencing of reduction, multiplies and squarings
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_ACC_BASE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RED;
        end
      end
      S_RED: begin
        if (stat_i.mul_done) begin
          cmd_o.wr_base = 1'b1;
          state_d       = S_TEST;
        end
      end
      S_TEST: begin
        priority if (stat_i.mod_small || stat_i.exp_zero) begin
          state_d = S_DONE;
        end else if (stat_i.exp_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_ACC_BASE;
          state_d         = S_MUL;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_BASE_SQR;
          state_d         = S_SQR;
        end
      end
      S_MUL: begin
        if (stat_i.mul_done) begin
          cmd_o.wr_acc    = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_BASE_SQR;
          state_d         = S_SQR;
        end
      end
      S_SQR: begin
        if (stat_i.mul_done) begin
          cmd_o.wr_base   = 1'b1;
          cmd_o.exp_shift = 1'b1;
          state_d         = S_TEST;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/mexp_checker.sv
module mexp_checker import mexp_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input operand_t power_result_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(power_result_o))
    else $error("result changed while stalled");

  // an accepted item keeps the input side busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again straight after an item");

  // a residue is always below the largest modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> power_result_o != '1)
    else $error("result not a residue");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

FILE: tb/modular_exponentiation_checker.sv
`timescale 1ns / 100ps

module modular_exponentiation_checker import mexp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     modulus_we_i,
  input  operand_t modulus_i,
  input  logic     in_valid_i,
  input  logic     in_stall_o,
  input  operand_t base_value_i,
  input  operand_t exponent_i,
  input  logic     out_valid_o,
  input  logic     out_stall_i,
  input  operand_t power_result_o,
  output int       mismatch_count_o,
  output int       outstanding_o,
  output int       checked_count_o
);

  // local copy of the modulus register
  operand_t modulus_q;
  // powers still owed by the block, oldest first
  operand_t expected_powers[$];
  operand_t expected_power;

  // base ** exponent mod modulus by right-to-left square-and-multiply
  function automatic operand_t power_mod(input operand_t base, input operand_t exponent,
                                         input operand_t modulus);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] e;
    if (modulus < 2) begin
      return '0;
    end
    acc = 64'd1;
    sq  = 64'(base) % 64'(modulus);
    e   = 64'(exponent);
    while (e != 0) begin
      if (e[0]) begin
        acc = (acc * sq) % 64'(modulus);
      end
      sq = (sq * sq) % 64'(modulus);
      e  = e >> 1;
    end
    return operand_t'(acc);
  endfunction

  // one line per mismatch, counted
  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatch_count_o++;
  endtask

  // watch both channels and the modulus port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q        <= MODULUS_RESET;
      expected_powers.delete();
      mismatch_count_o = 0;
      checked_count_o  = 0;
      outstanding_o    = 0;
    end else begin
      // item accepted: predict with the modulus in force before this edge
      if (in_valid_i && !in_stall_o) begin
        expected_powers.push_back(power_mod(base_value_i, exponent_i, modulus_q));
      end
      if (modulus_we_i) begin
        modulus_q <= modulus_i;
      end
      // result accepted: compare with oldest prediction
      if (out_valid_o && !out_stall_i) begin
        if (expected_powers.size() == 0) begin
          report_mismatch($sformatf("unexpected result power_result=%0d", power_result_o));
        end else begin
          expected_power = expected_powers.pop_front();
          checked_count_o++;
          if (power_result_o !== expected_power) begin
            report_mismatch($sformatf("power_result=%0d, predicted %0d",
                                      power_result_o, expected_power));
          end
        end
      end
      outstanding_o = expected_powers.size();
    end
  end

endmodule

FILE: tb/modular_exponentiation_test.sv
`timescale 1ns / 100ps

module modular_exponentiation_test import mexp_pkg::*;;

  localparam int       CYCLE_LIMIT = 3000000;
  localparam int       LONG_HOLD   = 4000;
  localparam int       PHASE_ITEMS = 45;
  localparam operand_t OP_MAX      = '1;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     modulus_we_i;
  operand_t modulus_i;
  logic     in_valid_i;
  logic     in_stall_o;
  operand_t base_value_i;
  operand_t exponent_i;
  logic     out_valid_o;
  logic     out_stall_i;
  operand_t power_result_o;

  int mismatch_count;
  int outstanding;
  int checked_count;

  int          cycle_count   = 0;
  int          items_sent    = 0;
  int          modulus_sets  = 1;
  bit          idle_on       = 1'b1;
  int unsigned hold_left     = 0;

  modular_exponentiation DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .modulus_we_i  (modulus_we_i),
    .modulus_i     (modulus_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .base_value_i  (base_value_i),
    .exponent_i    (exponent_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .power_result_o(power_result_o)
  );

  modular_exponentiation_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .modulus_we_i    (modulus_we_i),
    .modulus_i       (modulus_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .base_value_i    (base_value_i),
    .exponent_i      (exponent_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .power_result_o  (power_result_o),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding),
    .checked_count_o (checked_count)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: long hold-off on request, else a random wait per item
  initial begin
    int unsigned wait_left;
    wait_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (out_valid_o && wait_left != 0) begin
        out_stall_i <= 1'b1;
        wait_left--;
      end else begin
        out_stall_i <= 1'b0;
        // this item goes at the next edge, draw the wait for the next one
        if (out_valid_o) begin
          wait_left = idle_on ? $urandom_range(0, 9) : 0;
        end
      end
    end
  end

  // offer one item, called and returning at a falling edge
  task automatic send_item(input operand_t base, input operand_t exponent);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    base_value_i <= base;
    exponent_i   <= exponent;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // modulus write with the block idle
  task automatic write_modulus(input operand_t value);
    drain();
    repeat (4) @(negedge clk_i);
    modulus_we_i <= 1'b1;
    modulus_i    <= value;
    @(negedge clk_i);
    modulus_we_i <= 1'b0;
    modulus_sets++;
  endtask

  // random item: mostly full-width operands, some edge values
  task automatic random_item(input operand_t modulus);
    operand_t b;
    operand_t e;
    b = operand_t'($urandom);
    e = operand_t'($urandom);
    case ($urandom_range(0, 7))
      0: b = '0;
      1: b = modulus - 1'b1;
      2: b = modulus;
      3: b = operand_t'($urandom_range(0, 3));
      default: ;
    endcase
    case ($urandom_range(0, 9))
      5, 6, 7: e = operand_t'($urandom_range(0, 31));
      8:       e = OP_MAX;
      9:       e = operand_t'($urandom_range(0, 1));
      default: ;
    endcase
    send_item(b, e);
  endtask

  // stimulus
  initial begin
    operand_t phase_modulus;
    rst_ni       = 1'b0;
    modulus_we_i = 1'b0;
    modulus_i    = '0;
    in_valid_i   = 1'b0;
    base_value_i = '0;
    exponent_i   = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset modulus 23: zero exponent, zero base, base equal to the modulus, fermat
    send_item('0, '0);
    send_item('0, 30'd5);
    send_item(OP_MAX, OP_MAX);
    send_item(30'd22, 30'd1);
    send_item(30'd23, 30'd7);
    send_item(30'd5, 30'd22);
    send_item(OP_MAX, '0);

    // widest modulus
    write_modulus(OP_MAX);
    send_item(OP_MAX, 30'd1);
    send_item(OP_MAX - 1'b1, OP_MAX);
    send_item(30'd2, 30'd29);
    send_item(30'd1, OP_MAX);

    // smallest meaningful modulus
    write_modulus(30'd2);
    send_item(30'd3, OP_MAX);
    send_item(30'd4, '0);
    send_item(OP_MAX, 30'd3);

    // modulus one: everything is zero, zero exponent too
    write_modulus(30'd1);
    send_item('0, '0);
    send_item(30'd7, 30'd3);

    // modulus zero: answered with zero
    write_modulus('0);
    send_item('0, '0);
    send_item(OP_MAX, OP_MAX);

    // prime modulus, fermat check
    write_modulus(30'd1000003);
    send_item(30'd2, 30'd1000002);

    // random phases over several moduli
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1:       phase_modulus = operand_t'($urandom_range(3, 64));
        2:       phase_modulus = OP_MAX;
        4:       phase_modulus = operand_t'($urandom_range(0, 1));
        5:       phase_modulus = 30'd2;
        default: phase_modulus = operand_t'($urandom);
      endcase
      if (phase != 4 && phase_modulus < 2) begin
        phase_modulus = 30'd2;
      end
      write_modulus(phase_modulus);
      idle_on = (phase != 2) && ($urandom_range(0, 3) != 0);
      // receiver holds off while items keep coming so the block backs up
      if (phase == 0) begin
        hold_left = LONG_HOLD;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase != 2 && n % 15 == 0) begin
          idle_on = ($urandom_range(0, 2) != 0);
        end
        random_item(phase_modulus);
      end
    end

    // wait out the last results and any stray output
    drain();
    repeat (2000) @(negedge clk_i);

    $display("%0d items over %0d modulus settings, %0d results checked", items_sent,
             modulus_sets, checked_count);
    $display("moduli 0, 1, 2, 23 and all ones, zero and full-width exponents, long output stall");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: modular_exponentiation.f
rtl/mexp_pkg.sv
rtl/mexp_dpath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
rtl/mexp_checker.sv
tb/modular_exponentiation_checker.sv
tb/modular_exponentiation_test.sv
